### src/u16550_pkg.sv
// ----------------------------------------------------------------------------
// u16550_pkg
// Shared types, register codes and helper functions of the 16550-style
// UART register block.
// ----------------------------------------------------------------------------
package u16550_pkg;

  localparam int unsigned RX_DEPTH_DEF = 16;
  localparam int unsigned TX_DEPTH_DEF = 16;

  // Transaction kinds
  localparam logic [2:0] KIND_READ    = 3'd0;
  localparam logic [2:0] KIND_WRITE   = 3'd1;
  localparam logic [2:0] KIND_LINE_RX = 3'd2;
  localparam logic [2:0] KIND_TX_TAKE = 3'd3;
  localparam logic [2:0] KIND_TIMEOUT = 3'd4;

  // Register offsets
  localparam logic [2:0] REG_RBR = 3'd0;
  localparam logic [2:0] REG_IER = 3'd1;
  localparam logic [2:0] REG_IIR = 3'd2;
  localparam logic [2:0] REG_LCR = 3'd3;
  localparam logic [2:0] REG_MCR = 3'd4;
  localparam logic [2:0] REG_LSR = 3'd5;
  localparam logic [2:0] REG_MSR = 3'd6;
  localparam logic [2:0] REG_SCR = 3'd7;

  // Interrupt identification codes (low nibble of IIR)
  localparam logic [3:0] IIR_RLS  = 4'h6;
  localparam logic [3:0] IIR_RDA  = 4'h4;
  localparam logic [3:0] IIR_CTO  = 4'hC;
  localparam logic [3:0] IIR_THRE = 4'h2;
  localparam logic [3:0] IIR_MDM  = 4'h0;
  localparam logic [3:0] IIR_NONE = 4'h1;

  // Status flag bit positions
  localparam int unsigned FL_RLS  = 0;
  localparam int unsigned FL_BI   = 1;
  localparam int unsigned FL_CTO  = 2;
  localparam int unsigned FL_THRE = 3;
  localparam int unsigned FL_MDM  = 4;

  // Register bit positions
  localparam int unsigned LCR_DLAB = 7;
  localparam int unsigned MCR_DTR  = 0;
  localparam int unsigned MCR_RTS  = 1;
  localparam int unsigned MCR_OUT2 = 3;
  localparam int unsigned MCR_LOOP = 4;
  localparam int unsigned IER_RDA  = 0;
  localparam int unsigned IER_THRE = 1;
  localparam int unsigned IER_RLS  = 2;
  localparam int unsigned IER_MDM  = 3;
  localparam int unsigned FCR_EN   = 0;

  localparam logic [7:0] FCR_WR_MASK = 8'hF9;
  localparam logic [7:0] EMPTY_READ  = 8'hFF;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_cmd_t;

  // Receive trigger level from FCR bits 7:6
  function automatic logic [3:0] rx_trigger(input logic [1:0] sel);
    logic [3:0] lvl;
    case (sel)
      2'd0:    lvl = 4'd1;
      2'd1:    lvl = 4'd4;
      2'd2:    lvl = 4'd8;
      default: lvl = 4'd14;
    endcase
    return lvl;
  endfunction

  // Highest-priority pending interrupt cause
  function automatic logic [3:0] iir_cause(input logic [4:0] flags,
                                           input logic [7:0] ier,
                                           input logic       rda);
    logic [3:0] code;
    if (flags[FL_RLS] && ier[IER_RLS]) begin
      code = IIR_RLS;
    end else if (rda && ier[IER_RDA]) begin
      code = IIR_RDA;
    end else if (flags[FL_CTO] && ier[IER_RDA]) begin
      code = IIR_CTO;
    end else if (flags[FL_THRE] && ier[IER_THRE]) begin
      code = IIR_THRE;
    end else if (flags[FL_MDM] && ier[IER_MDM]) begin
      code = IIR_MDM;
    end else begin
      code = IIR_NONE;
    end
    return code;
  endfunction

endpackage

### src/u16550_fifo.sv
// ----------------------------------------------------------------------------
// u16550_fifo
// Circular FIFO with head pointer and fill count. The entry at the next head
// is read into a register every cycle, with bypass of a same-cycle write.
// ----------------------------------------------------------------------------
module u16550_fifo
  import u16550_pkg::*;
#(
  parameter int unsigned DEPTH = RX_DEPTH_DEF,
  parameter int unsigned WIDTH = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fifo_cmd_t                        cmd_i,
  input  logic [WIDTH-1:0]                 wr_data_i,
  output logic [WIDTH-1:0]                 head_data_o,
  output logic [$clog2(DEPTH+1)-1:0]       count_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [AW-1:0]    head_q, head_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW:0]      tail_sum;
  logic [CW:0]      tail_wrap;
  logic [AW-1:0]    tail;
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] head_data_q;

  always_comb begin
    tail_sum  = (CW+1)'(head_q) + (CW+1)'(count_q);
    tail_wrap = (tail_sum >= (CW+1)'(DEPTH)) ? tail_sum - (CW+1)'(DEPTH) : tail_sum;
    tail      = tail_wrap[AW-1:0];
    head_d    = head_q;
    if (cmd_i.pop) begin
      head_d = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
    end
    count_d = count_q + CW'(cmd_i.push) - CW'(cmd_i.pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[tail] <= wr_data_i;
    end
  end

  // Prefetch the next head entry; forward a write that lands on it
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && (tail == head_d)) begin
      head_data_q <= wr_data_i;
    end else begin
      head_data_q <= mem_q[head_d];
    end
  end

  assign head_data_o = head_data_q;
  assign count_o     = count_q;

endmodule

### src/uart_16550_register_block_unit.sv
// ----------------------------------------------------------------------------
// uart_16550_register_block_unit
// 16550-style UART register file with receive and transmit FIFOs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one transaction: a bus
//   read, a bus write, a received line byte, a line take of a transmit byte,
//   or a receive timeout, together with the current CTS/DSR pin levels.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result per
//   transaction: read data, interrupt line, transmitted byte and RTS/DTR.
//   Transactions pass an input register, then one pass of register and
//   FIFO-pointer logic into the result register. Throughput is one
//   transaction per cycle unless the output stalls; the FIFO head entry is
//   prefetched from memory every cycle so its single read port never limits it.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more transaction; in_stall_o rises only when
//   both are full.
//   Reset clears valid bits, control registers, FIFO pointers, counts and
//   status flags at once; data registers and FIFO storage need no clearing.
// ----------------------------------------------------------------------------
module uart_16550_register_block_unit
  import u16550_pkg::*;
#(
  parameter int unsigned RX_DEPTH = RX_DEPTH_DEF,
  parameter int unsigned TX_DEPTH = TX_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] kind_i,
  input  logic [2:0] reg_offset_i,
  input  logic [7:0] write_byte_i,
  input  logic [7:0] line_byte_i,
  input  logic       line_break_i,
  input  logic       cts_pin_i,
  input  logic       dsr_pin_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_byte_o,
  output logic       irq_out_o,
  output logic       tx_valid_o,
  output logic [7:0] tx_byte_o,
  output logic       rts_out_o,
  output logic       dtr_out_o
);

  localparam int unsigned RCW = $clog2(RX_DEPTH + 1);
  localparam int unsigned TCW = $clog2(TX_DEPTH + 1);

  // Input register
  logic       s1_valid_q, s1_valid_d;
  logic [2:0] s1_kind_q, s1_off_q;
  logic [7:0] s1_wbyte_q, s1_lbyte_q;
  logic       s1_brk_q, s1_cts_q, s1_dsr_q;
  logic       in_acc, adv;

  // Architectural state
  logic [7:0] dll_q, dll_d, dlm_q, dlm_d, ier_q, ier_d, lcr_q, lcr_d;
  logic [7:0] mcr_q, mcr_d, fcr_q, fcr_d, scr_q, scr_d;
  logic [4:0] fl_q, fl_d;
  logic [3:0] ml_q, ml_d;
  logic [RCW-1:0] brk_cnt_q, brk_cnt_d;

  // FIFO interface
  fifo_cmd_t      rx_cmd, tx_cmd, rx_op, tx_op;
  logic [8:0]     rx_wdata, rx_head;
  logic [7:0]     tx_head;
  logic [RCW-1:0] rx_cnt, rx_cnt_n;
  logic [TCW-1:0] tx_cnt;

  // Result register
  logic       out_valid_q, out_valid_d;
  logic [7:0] rd_q, rd_d, txb_q, txb_d;
  logic       irq_q, irq_d, txv_q, txv_d, rts_q, rts_d, dtr_q, dtr_d;

  // Working values
  logic       loop_pre, loop_post, dlab, rda_pre, rda_post, rx_full, tx_full;
  logic [1:0] lv_pre, lv_post;
  logic [3:0] cause;

  // Handshake
  assign adv         = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && !adv;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign s1_valid_d  = in_acc || (s1_valid_q && !adv);
  assign out_valid_d = adv || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind_q  <= kind_i;
      s1_off_q   <= reg_offset_i;
      s1_wbyte_q <= write_byte_i;
      s1_lbyte_q <= line_byte_i;
      s1_brk_q   <= line_break_i;
      s1_cts_q   <= cts_pin_i;
      s1_dsr_q   <= dsr_pin_i;
    end
  end

  always_comb begin
    dll_d    = dll_q;
    dlm_d    = dlm_q;
    ier_d    = ier_q;
    lcr_d    = lcr_q;
    mcr_d    = mcr_q;
    fcr_d    = fcr_q;
    scr_d    = scr_q;
    fl_d     = fl_q;
    rd_d     = EMPTY_READ;
    txv_d    = 1'b0;
    txb_d    = '0;
    rx_op    = '0;
    tx_op    = '0;
    rx_wdata = '0;
    cause    = IIR_NONE;

    loop_pre = mcr_q[MCR_LOOP];
    dlab     = lcr_q[LCR_DLAB];
    rx_full  = (rx_cnt == RCW'(RX_DEPTH));
    tx_full  = (tx_cnt == TCW'(TX_DEPTH));
    rda_pre  = (9'(rx_cnt) >= 9'(rx_trigger(fcr_q[7:6])));

    // Sample modem lines before the transaction
    lv_pre = loop_pre ? {mcr_q[MCR_DTR], mcr_q[MCR_RTS]} : {s1_dsr_q, s1_cts_q};
    if (lv_pre != ml_q[1:0]) begin
      fl_d[FL_MDM] = 1'b1;
    end
    ml_d = {ml_q[3:2], lv_pre};

    case (s1_kind_q)
      KIND_READ: begin
        case (s1_off_q)
          REG_RBR: begin
            if (dlab) begin
              rd_d = dll_q;
            end else if (rx_cnt != '0) begin
              rd_d = rx_head[7:0];
              if (rx_head[8]) begin
                fl_d[FL_BI]  = 1'b1;
                fl_d[FL_RLS] = 1'b1;
              end
              rx_op.pop    = 1'b1;
              fl_d[FL_CTO] = 1'b0;
            end
          end
          REG_IER: rd_d = dlab ? dlm_q : ier_q;
          REG_IIR: begin
            cause = iir_cause(fl_d, ier_q, rda_pre);
            if (cause == IIR_THRE) begin
              fl_d[FL_THRE] = 1'b0;
            end
            rd_d = {{2{fcr_q[FCR_EN]}}, 2'b00, cause};
          end
          REG_LCR: rd_d = lcr_q;
          REG_MCR: rd_d = mcr_q;
          REG_LSR: begin
            rd_d = {brk_cnt_q != '0, tx_cnt == '0,
                    loop_pre ? !rx_full : !tx_full,
                    fl_d[FL_BI], 3'b000, rx_cnt != '0};
            fl_d[FL_RLS] = 1'b0;
            fl_d[FL_BI]  = 1'b0;
          end
          REG_MSR: begin
            rd_d = {2'b00, ml_d[1:0], 2'b00, ml_d[1:0] ^ ml_d[3:2]};
            ml_d = {ml_d[1:0], ml_d[1:0]};
            fl_d[FL_MDM] = 1'b0;
          end
          default: rd_d = scr_q;
        endcase
      end
      KIND_WRITE: begin
        case (s1_off_q)
          REG_RBR: begin
            if (dlab) begin
              dll_d = s1_wbyte_q;
            end else begin
              fl_d[FL_THRE] = 1'b0;
              if (loop_pre) begin
                rx_op.push    = !rx_full;
                rx_wdata      = {1'b0, s1_wbyte_q};
                fl_d[FL_THRE] = 1'b1;
              end else begin
                tx_op.push = !tx_full;
              end
            end
          end
          REG_IER: begin
            if (dlab) begin
              dlm_d = s1_wbyte_q;
            end else begin
              if (s1_wbyte_q[IER_THRE] && !ier_q[IER_THRE] && (tx_cnt == '0)) begin
                fl_d[FL_THRE] = 1'b1;
              end
              ier_d = s1_wbyte_q;
            end
          end
          REG_IIR: fcr_d = s1_wbyte_q & FCR_WR_MASK;
          REG_LCR: lcr_d = s1_wbyte_q;
          REG_MCR: mcr_d = s1_wbyte_q;
          REG_SCR: scr_d = s1_wbyte_q;
          default: ;
        endcase
      end
      KIND_LINE_RX: begin
        if (!loop_pre) begin
          rx_op.push = !rx_full;
          rx_wdata   = {s1_brk_q, s1_lbyte_q};
        end
      end
      KIND_TX_TAKE: begin
        if (!loop_pre && (tx_cnt != '0)) begin
          txv_d     = 1'b1;
          txb_d     = tx_head;
          tx_op.pop = 1'b1;
          if (tx_cnt == TCW'(1)) begin
            fl_d[FL_THRE] = 1'b1;
          end
        end
      end
      KIND_TIMEOUT: begin
        if (rx_cnt != '0) begin
          fl_d[FL_CTO] = 1'b1;
        end
      end
      default: ;
    endcase

    // Sample modem lines again with the updated MCR
    loop_post = mcr_d[MCR_LOOP];
    lv_post   = loop_post ? {mcr_d[MCR_DTR], mcr_d[MCR_RTS]} : {s1_dsr_q, s1_cts_q};
    if (lv_post != ml_d[1:0]) begin
      fl_d[FL_MDM] = 1'b1;
    end
    ml_d = {ml_d[3:2], lv_post};

    rx_cnt_n  = rx_cnt + RCW'(rx_op.push) - RCW'(rx_op.pop);
    brk_cnt_d = brk_cnt_q + RCW'(rx_op.push && rx_wdata[8])
                          - RCW'(rx_op.pop && rx_head[8]);
    rda_post  = (9'(rx_cnt_n) >= 9'(rx_trigger(fcr_d[7:6])));
    irq_d     = mcr_d[MCR_OUT2] && (iir_cause(fl_d, ier_d, rda_post) != IIR_NONE);
    rts_d     = !loop_post && mcr_d[MCR_RTS];
    dtr_d     = !loop_post && mcr_d[MCR_DTR];
  end

  // Commit FIFO operations only when the transaction moves on
  always_comb begin
    rx_cmd.push = adv && rx_op.push;
    rx_cmd.pop  = adv && rx_op.pop;
    tx_cmd.push = adv && tx_op.push;
    tx_cmd.pop  = adv && tx_op.pop;
  end

  u16550_fifo #(
    .DEPTH (RX_DEPTH),
    .WIDTH (9)
  ) u_rx_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (rx_cmd),
    .wr_data_i   (rx_wdata),
    .head_data_o (rx_head),
    .count_o     (rx_cnt)
  );

  u16550_fifo #(
    .DEPTH (TX_DEPTH),
    .WIDTH (8)
  ) u_tx_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (tx_cmd),
    .wr_data_i   (s1_wbyte_q),
    .head_data_o (tx_head),
    .count_o     (tx_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dll_q     <= '0;
      dlm_q     <= '0;
      ier_q     <= '0;
      lcr_q     <= '0;
      mcr_q     <= '0;
      fcr_q     <= '0;
      scr_q     <= '0;
      fl_q      <= '0;
      ml_q      <= '0;
      brk_cnt_q <= '0;
    end else if (adv) begin
      dll_q     <= dll_d;
      dlm_q     <= dlm_d;
      ier_q     <= ier_d;
      lcr_q     <= lcr_d;
      mcr_q     <= mcr_d;
      fcr_q     <= fcr_d;
      scr_q     <= scr_d;
      fl_q      <= fl_d;
      ml_q      <= ml_d;
      brk_cnt_q <= brk_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_q  <= rd_d;
      irq_q <= irq_d;
      txv_q <= txv_d;
      txb_q <= txb_d;
      rts_q <= rts_d;
      dtr_q <= dtr_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_byte_o = rd_q;
  assign irq_out_o   = irq_q;
  assign tx_valid_o  = txv_q;
  assign tx_byte_o   = txb_q;
  assign rts_out_o   = rts_q;
  assign dtr_out_o   = dtr_q;

`ifndef SYNTHESIS
  a_brk_within_fifo : assert property (@(posedge clk_i) disable iff (!rst_ni)
    brk_cnt_q <= rx_cnt)
    else $error("break count exceeds receive FIFO fill");

  a_stall_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && out_stall_i) |-> in_stall_o)
    else $error("input taken while both stages are blocked");

  a_irq_needs_out2 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && irq_q) |-> mcr_q[MCR_OUT2])
    else $error("interrupt raised with OUT2 clear");

  a_take_sends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (s1_kind_q == KIND_TX_TAKE) && !mcr_q[MCR_LOOP] && (tx_cnt != '0))
      |=> (out_valid_q && txv_q))
    else $error("line take with queued data sent nothing");

  a_no_tx_in_loop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && mcr_q[MCR_LOOP]) |=> !txv_q)
    else $error("byte sent on the line in loopback");
`endif

endmodule
